>>> hw/rtl/rar_pkg.sv
// Shared types, codes and helpers for the rational ALU with reduction.
package rar_pkg;

    localparam int FIELD_WIDTH       = 32;
    localparam int RES_WIDTH         = 64;
    localparam int OPERAND_WIDTH_DEF = 32;

    localparam logic [RES_WIDTH-1:0] RES_MAG_MAX = {1'b0, {(RES_WIDTH-1){1'b1}}};

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef struct packed {
        op_t                            operation;
        logic signed [FIELD_WIDTH-1:0]  a_num;
        logic signed [FIELD_WIDTH-1:0]  a_den;
        logic signed [FIELD_WIDTH-1:0]  b_num;
        logic signed [FIELD_WIDTH-1:0]  b_den;
    } rar_in_t;

    typedef struct packed {
        logic signed [RES_WIDTH-1:0] res_num;
        logic signed [RES_WIDTH-1:0] res_den;
        logic                        math_error;
    } rar_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_SUM,
        ST_GCD_GO,
        ST_GCD_RUN,
        ST_DIVN_GO,
        ST_DIVN_RUN,
        ST_DIVD_GO,
        ST_DIVD_RUN,
        ST_DONE
    } rar_state_t;

    // Sign and magnitude to two's complement, magnitude clipped to the positive range.
    function automatic logic [RES_WIDTH-1:0] to_twos(input logic neg,
                                                     input logic [RES_WIDTH-1:0] mag);
        logic [RES_WIDTH-1:0] m;
        m = mag[RES_WIDTH-1] ? RES_MAG_MAX : mag;
        return neg ? (~m + RES_WIDTH'(1)) : m;
    endfunction

endpackage

>>> hw/rtl/rar_mul.sv
// Unsigned magnitude multiplier with a registered product.
module rar_mul import rar_pkg::*; #(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  logic                       aclk,
    input  logic [OPERAND_WIDTH-1:0]   x,
    input  logic [OPERAND_WIDTH-1:0]   y,
    output logic [2*OPERAND_WIDTH-1:0] p
);

    localparam int PW = 2 * OPERAND_WIDTH;

    logic [PW-1:0] p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= PW'(x) * PW'(y);
    end

    assign p = p_reg;

endmodule

>>> hw/rtl/rar_gcd.sv
// Iterative binary gcd of two non-zero magnitudes, one shift or subtract step a cycle.
module rar_gcd import rar_pkg::*; #(
    parameter int WIDTH = 2 * OPERAND_WIDTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [WIDTH-1:0] u_in,
    input  logic [WIDTH-1:0] v_in,
    output logic             done,
    output logic [WIDTH-1:0] g
);

    localparam int KW = $clog2(WIDTH);

    logic             busy_reg;
    logic             done_reg;
    logic [WIDTH-1:0] u_reg, u_next;
    logic [WIDTH-1:0] v_reg, v_next;
    logic [KW-1:0]    k_reg, k_next;
    logic [WIDTH-1:0] g_reg;
    logic             equal;

    assign equal = (u_reg == v_reg);

    always_comb begin
        u_next = u_reg;
        v_next = v_reg;
        k_next = k_reg;
        if (!u_reg[0] && !v_reg[0]) begin
            // common factor of two, kept in k
            u_next = u_reg >> 1;
            v_next = v_reg >> 1;
            k_next = k_reg + KW'(1);
        end else if (!u_reg[0]) begin
            u_next = u_reg >> 1;
        end else if (!v_reg[0]) begin
            v_next = v_reg >> 1;
        end else if (u_reg > v_reg) begin
            u_next = (u_reg - v_reg) >> 1;
        end else begin
            v_next = (v_reg - u_reg) >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && equal) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            u_reg <= u_in;
            v_reg <= v_in;
            k_reg <= '0;
        end else if (busy_reg && !equal) begin
            u_reg <= u_next;
            v_reg <= v_next;
            k_reg <= k_next;
        end
        if (busy_reg && equal) begin
            g_reg <= u_reg << k_reg;
        end
    end

    assign done = done_reg;
    assign g    = g_reg;

endmodule

>>> hw/rtl/rar_div.sv
// Restoring serial divider, one quotient bit a cycle; reused for numerator and denominator.
module rar_div import rar_pkg::*; #(
    parameter int WIDTH = 2 * OPERAND_WIDTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             done,
    output logic [WIDTH-1:0] quotient
);

    localparam int CW = $clog2(WIDTH + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CW-1:0]    cnt_reg;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] dsr_reg;
    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   diff;
    logic             qbit;

    always_comb begin
        trial    = {rem_reg, quo_reg[WIDTH-1]};
        diff     = trial - {1'b0, dsr_reg};
        qbit     = (trial >= {1'b0, dsr_reg});
        rem_next = qbit ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
        quo_next = {quo_reg[WIDTH-2:0], qbit};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(WIDTH);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> hw/rtl/rational_alu_reduce.sv
// Rational ALU: add, subtract, multiply or divide two fractions and reduce the result.
//
// Input channel s_valid/s_ready/s_data carries the operation and the four operands;
// only the low OPERAND_WIDTH bits of each operand are used, sign-extended.
// Result channel m_valid/m_ready/m_data carries the reduced numerator and denominator
// (signs kept as computed) and math_error.
// One transaction is worked on at a time; s_ready is high only while the sequencer idles.
// An ordinary item takes three multiply steps on the shared multiplier, one sum
// step, the binary gcd and two serial divisions, numerator then denominator.
// Error items (zero denominator, divide by zero) and zero numerators bypass the gcd
// and divider loops.
// The result sits in an output register, so the next item may be taken while it waits;
// a stalled receiver holds that register, and the sequencer waits at its last step
// until the register frees up.
// Reset (aresetn, synchronous, active low) returns the sequencer to idle and drops m_valid.
module rational_alu_reduce import rar_pkg::*; #(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  rar_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output rar_out_t m_data
);

    localparam int W  = OPERAND_WIDTH;
    localparam int PW = 2 * OPERAND_WIDTH;

    function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
        return v[W-1] ? (~v + W'(1)) : v;
    endfunction

    rar_state_t state_reg, state_next;

    op_t            op_reg;
    logic           an_neg_reg, ad_neg_reg, bn_neg_reg, bd_neg_reg;
    logic [W-1:0]   an_mag_reg, ad_mag_reg, bn_mag_reg, bd_mag_reg;
    logic           err_reg;
    logic           zero_reg;
    logic           num_neg_reg, aux_neg_reg, den_neg_reg;
    logic [PW-1:0]  num_mag_reg, aux_mag_reg, den_mag_reg, qn_reg;
    rar_out_t       out_reg;
    logic           m_valid_reg;

    // input decode
    logic [W-1:0]   in_an, in_ad, in_bn, in_bd;
    logic           in_err;

    // sequencer outputs
    logic [W-1:0]   mul_x, mul_y;
    logic           gcd_start, div_start, out_load;
    logic [PW-1:0]  div_dividend;

    // shared units
    logic [PW-1:0]  mul_p;
    logic           gcd_done, div_done;
    logic [PW-1:0]  gcd_g, div_q;

    // sum stage
    logic [PW-1:0]  sum_add, sum_diff, sum_mag;
    logic           sum_ge, sum_neg, sum_zero;

    assign in_an  = mag_of(s_data.a_num[W-1:0]);
    assign in_ad  = mag_of(s_data.a_den[W-1:0]);
    assign in_bn  = mag_of(s_data.b_num[W-1:0]);
    assign in_bd  = mag_of(s_data.b_den[W-1:0]);
    assign in_err = (in_ad == '0) || (in_bd == '0) ||
                    ((s_data.operation == OP_DIV) && (in_bn == '0));

    always_comb begin
        sum_add  = num_mag_reg + aux_mag_reg;
        sum_ge   = (num_mag_reg >= aux_mag_reg);
        sum_diff = sum_ge ? (num_mag_reg - aux_mag_reg) : (aux_mag_reg - num_mag_reg);
        sum_mag  = num_mag_reg;
        sum_neg  = num_neg_reg;
        if ((op_reg == OP_ADD) || (op_reg == OP_SUB)) begin
            if (num_neg_reg == aux_neg_reg) begin
                sum_mag = sum_add;
            end else begin
                sum_mag = sum_diff;
                sum_neg = sum_ge ? num_neg_reg : aux_neg_reg;
            end
        end
        sum_zero = (sum_mag == '0);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = in_err ? ST_DONE : ST_MUL0;
                end
            end
            ST_MUL0:     state_next = ST_MUL1;
            ST_MUL1:     state_next = ST_MUL2;
            ST_MUL2:     state_next = ST_SUM;
            ST_SUM:      state_next = sum_zero ? ST_DONE : ST_GCD_GO;
            ST_GCD_GO:   state_next = ST_GCD_RUN;
            ST_GCD_RUN: begin
                if (gcd_done) begin
                    state_next = ST_DIVN_GO;
                end
            end
            ST_DIVN_GO:  state_next = ST_DIVN_RUN;
            ST_DIVN_RUN: begin
                if (div_done) begin
                    state_next = ST_DIVD_GO;
                end
            end
            ST_DIVD_GO:  state_next = ST_DIVD_RUN;
            ST_DIVD_RUN: begin
                if (div_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_ready      = 1'b0;
        gcd_start    = 1'b0;
        div_start    = 1'b0;
        out_load     = 1'b0;
        div_dividend = num_mag_reg;
        mul_x        = an_mag_reg;
        mul_y        = bd_mag_reg;
        case (state_reg)
            ST_IDLE:    s_ready = 1'b1;
            ST_MUL0: begin
                mul_x = an_mag_reg;
                mul_y = (op_reg == OP_MUL) ? bn_mag_reg : bd_mag_reg;
            end
            ST_MUL1: begin
                mul_x = ad_mag_reg;
                mul_y = bn_mag_reg;
            end
            ST_MUL2: begin
                mul_x = ad_mag_reg;
                mul_y = (op_reg == OP_DIV) ? bn_mag_reg : bd_mag_reg;
            end
            ST_GCD_GO:  gcd_start = 1'b1;
            ST_DIVN_GO: begin
                div_start    = 1'b1;
                div_dividend = num_mag_reg;
            end
            ST_DIVD_GO: begin
                div_start    = 1'b1;
                div_dividend = den_mag_reg;
            end
            ST_DONE:    out_load = !m_valid_reg || m_ready;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_reg     <= s_data.operation;
                    an_neg_reg <= s_data.a_num[W-1];
                    ad_neg_reg <= s_data.a_den[W-1];
                    bn_neg_reg <= s_data.b_num[W-1];
                    bd_neg_reg <= s_data.b_den[W-1];
                    an_mag_reg <= in_an;
                    ad_mag_reg <= in_ad;
                    bn_mag_reg <= in_bn;
                    bd_mag_reg <= in_bd;
                    err_reg    <= in_err;
                    zero_reg   <= 1'b0;
                end
            end
            ST_MUL1: begin
                num_mag_reg <= mul_p;
                num_neg_reg <= an_neg_reg ^ ((op_reg == OP_MUL) ? bn_neg_reg : bd_neg_reg);
            end
            ST_MUL2: begin
                aux_mag_reg <= mul_p;
                aux_neg_reg <= ad_neg_reg ^ bn_neg_reg ^ (op_reg == OP_SUB);
            end
            ST_SUM: begin
                den_mag_reg <= mul_p;
                den_neg_reg <= ad_neg_reg ^ ((op_reg == OP_DIV) ? bn_neg_reg : bd_neg_reg);
                num_mag_reg <= sum_mag;
                num_neg_reg <= sum_neg;
                zero_reg    <= sum_zero;
            end
            ST_DIVN_RUN: begin
                if (div_done) begin
                    qn_reg <= div_q;
                end
            end
            default: begin
            end
        endcase

        if (out_load) begin
            if (err_reg) begin
                out_reg.res_num    <= '0;
                out_reg.res_den    <= '0;
                out_reg.math_error <= 1'b1;
            end else if (zero_reg) begin
                out_reg.res_num    <= '0;
                out_reg.res_den    <= RES_WIDTH'(1);
                out_reg.math_error <= 1'b0;
            end else begin
                out_reg.res_num    <= to_twos(num_neg_reg, RES_WIDTH'(qn_reg));
                out_reg.res_den    <= to_twos(den_neg_reg, RES_WIDTH'(div_q));
                out_reg.math_error <= 1'b0;
            end
        end
    end

    rar_mul #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_mul (
        .aclk (aclk),
        .x    (mul_x),
        .y    (mul_y),
        .p    (mul_p)
    );

    rar_gcd #(
        .WIDTH (PW)
    ) u_gcd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (gcd_start),
        .u_in    (num_mag_reg),
        .v_in    (den_mag_reg),
        .done    (gcd_done),
        .g       (gcd_g)
    );

    rar_div #(
        .WIDTH (PW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (gcd_g),
        .done     (div_done),
        .quotient (div_q)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

>>> tb/sv/tb.sv
// Testbench for rational_alu_reduce: self-checking fraction arithmetic with gcd reduction.
`timescale 1ns / 1ps

module tb;
    import rar_pkg::*;

    localparam int OPW            = OPERAND_WIDTH_DEF;
    localparam int MAX_POS        = 32'h7FFF_FFFF;
    localparam int MOST_NEG       = 32'h8000_0000;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 300;
    localparam int MAX_REPORTS    = 10;

    typedef struct {
        logic        neg;
        logic [63:0] mag;
    } signed_mag_t;

    logic     aclk;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    rar_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    rar_out_t m_data;

    rar_out_t expected_fractions[$];
    rar_out_t want_res;
    int       send_idle_pct  = 0;
    int       recv_stall_pct = 0;
    int       mismatch_count = 0;
    int       results_checked = 0;
    int       error_items    = 0;
    int       zero_results   = 0;
    int       sent_by_op[4]  = '{0, 0, 0, 0};
    int       quiet_cycles   = 0;

    rational_alu_reduce #(.OPERAND_WIDTH(OPW)) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic signed_mag_t to_sign_mag(input logic [FIELD_WIDTH-1:0] raw);
        signed_mag_t r;
        logic [63:0] mask, sbit, v;
        mask  = (64'd1 << OPW) - 64'd1;
        sbit  = 64'd1 << (OPW - 1);
        v     = 64'(raw) & mask;
        r.neg = (v & sbit) != 0;
        r.mag = r.neg ? ((~v + 64'd1) & mask) : v;
        // most negative operand has no positive twin
        if (r.neg && r.mag == 0) r.mag = sbit;
        return r;
    endfunction

    function automatic signed_mag_t mag_mul(input signed_mag_t x, input signed_mag_t y);
        signed_mag_t r;
        r.mag = x.mag * y.mag;
        r.neg = (x.neg != y.neg) && r.mag != 0;
        return r;
    endfunction

    function automatic signed_mag_t mag_add(input signed_mag_t x, input signed_mag_t y);
        signed_mag_t r;
        if (x.neg == y.neg) begin
            r.neg = x.neg;
            r.mag = x.mag + y.mag;
        end else if (x.mag >= y.mag) begin
            r.neg = x.neg;
            r.mag = x.mag - y.mag;
        end else begin
            r.neg = y.neg;
            r.mag = y.mag - x.mag;
        end
        if (r.mag == 0) r.neg = 1'b0;
        return r;
    endfunction

    // clip magnitude to the positive range, then apply the sign
    function automatic logic [RES_WIDTH-1:0] to_result_word(input signed_mag_t s);
        logic [63:0] m;
        m = (s.mag > RES_MAG_MAX) ? RES_MAG_MAX : s.mag;
        return s.neg ? (~m + 64'd1) : m;
    endfunction

    function automatic rar_out_t predict_fraction(input rar_in_t item);
        signed_mag_t an, ad, bn, bd, num, den;
        logic [63:0] g, r, t;
        rar_out_t res;
        an  = to_sign_mag(item.a_num);
        ad  = to_sign_mag(item.a_den);
        bn  = to_sign_mag(item.b_num);
        bd  = to_sign_mag(item.b_den);
        res = '0;
        if (ad.mag == 0 || bd.mag == 0 || (item.operation == OP_DIV && bn.mag == 0)) begin
            res.math_error = 1'b1;
            return res;
        end
        case (item.operation)
            OP_ADD, OP_SUB: begin
                if (item.operation == OP_SUB) bn.neg = !bn.neg;
                num = mag_add(mag_mul(an, bd), mag_mul(ad, bn));
                den = mag_mul(ad, bd);
            end
            OP_MUL: begin
                num = mag_mul(an, bn);
                den = mag_mul(ad, bd);
            end
            default: begin
                num = mag_mul(an, bd);
                den = mag_mul(ad, bn);
            end
        endcase
        if (num.mag == 0) begin
            res.res_den = 64'sd1;
            return res;
        end
        g = num.mag;
        r = den.mag;
        while (r != 0) begin
            t = g % r;
            g = r;
            r = t;
        end
        num.mag = num.mag / g;
        den.mag = den.mag / g;
        res.res_num = to_result_word(num);
        res.res_den = to_result_word(den);
        return res;
    endfunction

    // ---------------------------------------------------------------- driving

    // valid stays up between back-to-back transactions; only dropped for a gap
    task automatic send_operands(input op_t op, input int an, input int ad,
                                 input int bn, input int bd);
        rar_in_t  item;
        rar_out_t res;
        item.operation = op;
        item.a_num     = an;
        item.a_den     = ad;
        item.b_num     = bn;
        item.b_den     = bd;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        res = predict_fraction(item);
        expected_fractions.push_back(res);
        sent_by_op[op]++;
        if (res.math_error) error_items++;
        else if (res.res_num == 0) zero_results++;
    endtask

    task automatic drain_pipeline();
        s_valid <= 1'b0;
        while (expected_fractions.size() != 0) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic int pick_operand();
        int sel;
        int v;
        sel = $urandom_range(0, 99);
        if (sel < 35) begin
            v = int'($urandom_range(0, 60)) - 30;
        end else if (sel < 60) begin
            v = int'($urandom_range(0, 2000000)) - 1000000;
        end else if (sel < 92) begin
            v = int'($urandom);
        end else begin
            case ($urandom_range(0, 4))
                0:       v = MAX_POS;
                1:       v = -MAX_POS;
                2:       v = MOST_NEG;
                3:       v = 1;
                default: v = -1;
            endcase
        end
        return v;
    endfunction

    task automatic run_random_batch(input int count);
        for (int i = 0; i < count; i++) begin
            send_operands(op_t'($urandom_range(0, 3)), pick_operand(), pick_operand(),
                          pick_operand(), pick_operand());
        end
        drain_pipeline();
    endtask

    // ---------------------------------------------------------------- checking

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_checked++;
            if (expected_fractions.size() == 0) begin
                if (mismatch_count < MAX_REPORTS)
                    $display("unexpected result transaction: %0d/%0d err=%0b",
                             m_data.res_num, m_data.res_den, m_data.math_error);
                mismatch_count++;
            end else begin
                want_res = expected_fractions.pop_front();
                if (m_data.res_num !== want_res.res_num ||
                    m_data.res_den !== want_res.res_den ||
                    m_data.math_error !== want_res.math_error) begin
                    if (mismatch_count < MAX_REPORTS)
                        $display("mismatch: expected %0d/%0d err=%0b, got %0d/%0d err=%0b",
                                 want_res.res_num, want_res.res_den, want_res.math_error,
                                 m_data.res_num, m_data.res_den, m_data.math_error);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge aclk);
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // ---------------------------------------------------------------- tests

    task automatic test_directed_fractions();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_operands(OP_ADD, 1, 2, 1, 3);
        send_operands(OP_SUB, 1, 2, 1, 3);
        send_operands(OP_MUL, 2, 3, 3, 4);
        send_operands(OP_DIV, 2, 3, 4, 5);
        // numerator cancels to zero
        send_operands(OP_ADD, 1, 2, -1, 2);
        send_operands(OP_MUL, 0, 5, 3, 7);
        send_operands(OP_DIV, 0, 4, 3, 5);
        // zero denominators and zero divisor
        send_operands(OP_ADD, 1, 0, 1, 2);
        send_operands(OP_SUB, 1, 2, 1, 0);
        send_operands(OP_MUL, 0, 0, 0, 0);
        send_operands(OP_DIV, 3, 4, 0, 5);
        send_operands(OP_DIV, 0, 4, 0, 5);
        // negative denominators are kept
        send_operands(OP_MUL, 1, -2, 1, 3);
        send_operands(OP_ADD, 1, -2, 1, -3);
        send_operands(OP_DIV, 6, -4, -9, 8);
        // extremes of the operand range
        send_operands(OP_ADD, MAX_POS, 1, MAX_POS, 1);
        send_operands(OP_MUL, MAX_POS, 1, MAX_POS, 1);
        send_operands(OP_MUL, -MAX_POS, 1, -MAX_POS, -MAX_POS);
        send_operands(OP_SUB, MAX_POS, MAX_POS - 1, -MAX_POS, MAX_POS - 2);
        send_operands(OP_DIV, -MAX_POS, 3, MAX_POS, -7);
        // largest sum magnitude, reduced away again
        send_operands(OP_ADD, MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG);
        send_operands(OP_ADD, MOST_NEG, 1, MOST_NEG, 1);
        send_operands(OP_SUB, 32'h5555_5555, 32'h2AAA_AAAB, 32'hAAAA_AAAA, 32'hD555_5555);
        drain_pipeline();
    endtask

    task automatic test_back_to_back();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random_batch(388);
    endtask

    task automatic test_sender_gaps();
        send_idle_pct  = 83;
        recv_stall_pct = 0;
        run_random_batch(388);
    endtask

    task automatic test_receiver_stalls();
        send_idle_pct  = 0;
        recv_stall_pct = 83;
        run_random_batch(388);
    endtask

    task automatic test_mixed_idling();
        send_idle_pct  = 37;
        recv_stall_pct = 37;
        run_random_batch(388);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_fractions();
        test_back_to_back();
        test_sender_gaps();
        test_receiver_stalls();
        test_mixed_idling();
        recv_stall_pct = 0;
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("covered: add %0d, sub %0d, mul %0d, div %0d transactions; %0d checked",
                 sent_by_op[OP_ADD], sent_by_op[OP_SUB], sent_by_op[OP_MUL],
                 sent_by_op[OP_DIV], results_checked);
        $display("error cases %0d, zero results %0d, mismatches %0d, still pending %0d",
                 error_items, zero_results, mismatch_count, expected_fractions.size());
        if (mismatch_count == 0 && expected_fractions.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
